// ===== rtl/rmth_pkg.sv =====
package rmth_pkg;

   localparam int unsigned HEAP_DEPTH_DEF  = 1024;
   localparam int unsigned VALUE_WIDTH_DEF = 32;
   localparam int unsigned IN_VALUE_W      = 32;
   localparam int unsigned OUT_MEDIAN_W    = 32;
   localparam int unsigned OUT_COUNT_W     = 12;

   typedef struct packed {
      logic [IN_VALUE_W-1:0] value;
      logic                  restart;
   } req_type;

   typedef struct packed {
      logic [OUT_MEDIAN_W-1:0] median;
      logic [OUT_COUNT_W-1:0]  count;
      logic                    full_res;
   } rsp_type;

   // heap operation codes
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_PUSH  = 2'd1,
      OP_POP   = 2'd2
   } heap_op_type;

   // controller to datapath
   typedef struct packed {
      logic        go;
      heap_op_type op;
      logic        sel_upper;
      logic        push_src_pop;
      logic        clear;
      logic        set_median;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;
      logic empty;
      logic above_median;
      logic lower_gt_upper;
      logic upper_gt_lower;
      logic lower_full;
      logic upper_full;
   } dp_sts_type;

endpackage

// ===== rtl/rmth_heap.sv =====
module rmth_heap #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned VW    = 32,
   parameter bit          IS_MAX = 1'b1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     push,
   input  logic                     pop,
   input  logic [VW-1:0]            push_value,
   output logic                     done,
   output logic [VW-1:0]            top_value,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import rmth_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_UP_RD, S_UP_CMP, S_POP_RDL, S_POP_WAIT, S_DN_RD1, S_DN_RD2,
      S_DN_WAIT, S_DN_CMP, S_FIN
   } state_type;

   logic [VW-1:0]  mem [DEPTH];
   logic [VW-1:0]  rd_ff;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [VW-1:0]  wr_data;

   state_type      state_ff;
   logic [CW-1:0]  cnt_ff;
   logic [CW:0]    pos_ff;       // 1-based node
   logic [VW-1:0]  val_ff;       // value being placed
   logic [VW-1:0]  top_ff;
   logic [VW-1:0]  c1_ff;
   logic           has2_ff;

   // compare in heap order
   function automatic logic above(input logic [VW-1:0] a, input logic [VW-1:0] b);
      above = IS_MAX ? (a > b) : (a < b);
   endfunction

   // memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   logic [CW:0] par;
   logic [CW:0] ch;
   assign par = pos_ff >> 1;
   assign ch  = pos_ff << 1;

   // combinational memory control
   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = val_ff;
      case (state_ff)
         S_UP_RD:   rd_addr = AW'(par - 1'b1);
         S_UP_CMP: begin
            if (pos_ff > 1 && above(val_ff, rd_ff)) begin
               wr_en = 1'b1; wr_addr = AW'(pos_ff - 1'b1); wr_data = rd_ff;
            end else begin
               wr_en = 1'b1; wr_addr = AW'(pos_ff - 1'b1);
            end
         end
         S_POP_RDL: rd_addr = AW'(cnt_ff - 1'b1);
         S_DN_RD1:  rd_addr = AW'(ch - 1'b1);
         S_DN_RD2:  rd_addr = AW'(ch);
         // hold the right child address so it is still in rd_ff at the compare
         S_DN_WAIT: rd_addr = AW'(ch);
         S_DN_CMP: begin
            if (ch <= {1'b0, cnt_ff}) begin
               if (has2_ff && above(rd_ff, c1_ff)) begin
                  if (above(rd_ff, val_ff)) begin
                     wr_en = 1'b1; wr_addr = AW'(pos_ff - 1'b1); wr_data = rd_ff;
                  end
               end else if (above(c1_ff, val_ff)) begin
                  wr_en = 1'b1; wr_addr = AW'(pos_ff - 1'b1); wr_data = c1_ff;
               end
            end
         end
         S_FIN: begin
            if (cnt_ff != '0) begin
               wr_en = 1'b1; wr_addr = AW'(pos_ff - 1'b1);
            end
         end
         default: ;
      endcase
   end

   logic take_right;
   logic moves;
   assign take_right = has2_ff && above(rd_ff, c1_ff);
   assign moves = take_right ? above(rd_ff, val_ff) : above(c1_ff, val_ff);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         done     <= 1'b0;
      end else begin
         done <= 1'b0;
         if (clear) cnt_ff <= '0;
         case (state_ff)
            S_IDLE: begin
               if (push) begin
                  cnt_ff   <= cnt_ff + 1'b1;
                  pos_ff   <= {1'b0, cnt_ff} + 1'b1;
                  val_ff   <= push_value;
                  state_ff <= S_UP_RD;
               end else if (pop) begin
                  state_ff <= S_POP_RDL;
               end
            end
            S_UP_RD: state_ff <= S_UP_CMP;
            S_UP_CMP: begin
               if (pos_ff > 1 && above(val_ff, rd_ff)) begin
                  pos_ff   <= par;
                  state_ff <= S_UP_RD;
               end else begin
                  if (pos_ff == 1) top_ff <= val_ff;
                  done     <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_POP_RDL: begin
               cnt_ff   <= cnt_ff - 1'b1;
               pos_ff   <= (CW+1)'(1);
               state_ff <= S_POP_WAIT;
            end
            S_POP_WAIT: begin
               val_ff   <= rd_ff;
               state_ff <= S_DN_RD1;
            end
            S_DN_RD1: begin
               if (ch > {1'b0, cnt_ff}) state_ff <= S_FIN;
               else state_ff <= S_DN_RD2;
            end
            S_DN_RD2: begin
               c1_ff    <= rd_ff;
               has2_ff  <= ch < {1'b0, cnt_ff};
               state_ff <= S_DN_WAIT;
            end
            S_DN_WAIT: state_ff <= S_DN_CMP;
            S_DN_CMP: begin
               if (moves) begin
                  if (pos_ff == 1) top_ff <= take_right ? rd_ff : c1_ff;
                  pos_ff   <= take_right ? ch + 1'b1 : ch;
                  state_ff <= S_DN_RD1;
               end else state_ff <= S_FIN;
            end
            S_FIN: begin
               if (pos_ff == 1) top_ff <= val_ff;
               done     <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign top_value = top_ff;
   assign count     = cnt_ff;

endmodule

// ===== rtl/rmth_datapath.sv =====
module rmth_datapath #(
   parameter int unsigned HEAP_DEPTH  = rmth_pkg::HEAP_DEPTH_DEF,
   parameter int unsigned VALUE_WIDTH = rmth_pkg::VALUE_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  rmth_pkg::req_type    req,
   input  rmth_pkg::dp_cmd_type cmd,
   output rmth_pkg::dp_sts_type sts,
   output rmth_pkg::rsp_type    rsp_data
);
   import rmth_pkg::*;

   localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
   localparam int unsigned VW = VALUE_WIDTH;

   logic [VW-1:0] v_ff;
   logic [VW-1:0] moved_ff;
   logic [VW-1:0] med_ff;
   logic [VW-1:0] lo_top, up_top, push_val;
   logic [CW-1:0] lo_cnt, up_cnt;
   logic          lo_done, up_done;
   logic          lo_push, lo_pop, up_push, up_pop;

   // latch item value, capture popped top
   always_ff @(posedge clock) begin
      if (load) v_ff <= VW'(req.value);
      if (cmd.go && cmd.op == OP_POP) moved_ff <= cmd.sel_upper ? up_top : lo_top;
   end

   // median register
   always_ff @(posedge clock) begin
      if (reset) med_ff <= '0;
      else if (cmd.set_median) begin
         if (lo_cnt > up_cnt) med_ff <= lo_top;
         else if (up_cnt > lo_cnt) med_ff <= up_top;
         else if (lo_cnt != '0) med_ff <= (lo_top > up_top) ? up_top : lo_top;
      end
   end

   assign push_val = cmd.push_src_pop ? moved_ff : v_ff;
   assign lo_push = cmd.go && cmd.op == OP_PUSH && !cmd.sel_upper;
   assign up_push = cmd.go && cmd.op == OP_PUSH &&  cmd.sel_upper;
   assign lo_pop  = cmd.go && cmd.op == OP_POP  && !cmd.sel_upper;
   assign up_pop  = cmd.go && cmd.op == OP_POP  &&  cmd.sel_upper;

   rmth_heap #(.DEPTH(HEAP_DEPTH), .VW(VW), .IS_MAX(1'b1)) u_lower (
      .clock, .reset, .clear(cmd.clear), .push(lo_push), .pop(lo_pop),
      .push_value(push_val), .done(lo_done), .top_value(lo_top), .count(lo_cnt));

   rmth_heap #(.DEPTH(HEAP_DEPTH), .VW(VW), .IS_MAX(1'b0)) u_upper (
      .clock, .reset, .clear(cmd.clear), .push(up_push), .pop(up_pop),
      .push_value(push_val), .done(up_done), .top_value(up_top), .count(up_cnt));

   logic [CW:0] total;
   assign total = {1'b0, lo_cnt} + {1'b0, up_cnt};

   always_comb begin
      sts.done           = lo_done | up_done;
      sts.empty          = (total == '0);
      sts.above_median   = v_ff > med_ff;
      sts.lower_gt_upper = lo_cnt == up_cnt + 1'b1;
      sts.upper_gt_lower = up_cnt == lo_cnt + 1'b1;
      sts.lower_full     = lo_cnt >= CW'(HEAP_DEPTH);
      sts.upper_full     = up_cnt >= CW'(HEAP_DEPTH);
   end

   assign rsp_data.median   = OUT_MEDIAN_W'(med_ff);
   assign rsp_data.count    = OUT_COUNT_W'(total);
   assign rsp_data.full_res = 1'b0;

endmodule

// ===== rtl/rmth_ctrl.sv =====
module rmth_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 restart,
   input  rmth_pkg::dp_sts_type sts,
   output logic                 busy,
   output logic                 load,
   output rmth_pkg::dp_cmd_type cmd,
   output logic                 rsp_valid,
   output logic                 full_flag
);
   import rmth_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECIDE, S_WAIT1, S_PUSH2, S_WAIT2, S_MED, S_OUT
   } state_type;

   state_type state_ff;
   logic      second_ff;   // second push pending after move
   logic      tgt_up_ff;   // heap for the new value
   logic      restart_ff;

   always_comb begin
      load = start && !busy;
      cmd  = '0;
      cmd.op = OP_NONE;
      cmd.clear = load && restart;
      case (state_ff)
         S_DECIDE: begin
            cmd.go = 1'b1;
            if (sts.empty) begin
               cmd.op = OP_PUSH; cmd.sel_upper = 1'b0;
            end else if (sts.above_median) begin
               if (sts.upper_gt_lower) begin
                  cmd.op = OP_POP; cmd.sel_upper = 1'b1;
               end else if (sts.upper_full) cmd.go = 1'b0;
               else begin
                  cmd.op = OP_PUSH; cmd.sel_upper = 1'b1;
               end
            end else begin
               if (sts.lower_gt_upper) begin
                  cmd.op = OP_POP; cmd.sel_upper = 1'b0;
               end else if (sts.lower_full) cmd.go = 1'b0;
               else begin
                  cmd.op = OP_PUSH; cmd.sel_upper = 1'b0;
               end
            end
         end
         S_PUSH2: begin
            cmd.go = 1'b1; cmd.op = OP_PUSH;
            cmd.sel_upper = second_ff ? !tgt_up_ff : tgt_up_ff;
            cmd.push_src_pop = second_ff;
         end
         S_MED: cmd.set_median = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy      <= 1'b0;
         rsp_valid <= 1'b0;
         full_flag <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: if (load) begin
               busy     <= 1'b1;
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               full_flag <= !cmd.go;
               tgt_up_ff <= !sts.empty && sts.above_median;
               second_ff <= cmd.op == OP_POP;
               state_ff  <= cmd.go ? S_WAIT1 : S_OUT;
            end
            S_WAIT1: if (sts.done) state_ff <= second_ff ? S_PUSH2 : S_MED;
            S_PUSH2: state_ff <= S_WAIT2;
            S_WAIT2: if (sts.done) begin
               if (second_ff) begin
                  second_ff <= 1'b0;
                  state_ff  <= S_PUSH2;
               end else state_ff <= S_MED;
            end
            S_MED: state_ff <= S_OUT;
            S_OUT: begin
               rsp_valid <= 1'b1;
               busy      <= 1'b0;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/running_median_two_heaps_top.sv =====
// running median tracker, two heaps
// req channel: drive req_data and start while busy is low; the item is
// taken at that edge and busy rises until its result is out.
// rsp channel: rsp_valid pulses one cycle with median, count and full_res.
// the receiver cannot stall; the result is shown exactly once.
// a restart item empties both heaps before inserting its value.
// heap walks: a push walks up one level per read and compare, a pop
// walks down one level per read left, read right, wait and compare; the
// steps are set by the single read port of each heap memory.
// a plain insert does one push; an insert with a move does a pop and
// two pushes; a refused item goes straight to its result without
// touching either heap.
// one item at a time; next item may start the cycle rsp_valid is high.
// reset clears counts and median; heap memories need no clearing since
// entries above the count are never used.
module running_median_two_heaps_top #(
   parameter int unsigned HEAP_DEPTH  = rmth_pkg::HEAP_DEPTH_DEF,
   parameter int unsigned VALUE_WIDTH = rmth_pkg::VALUE_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rmth_pkg::req_type req_data,
   output logic              rsp_valid,
   output rmth_pkg::rsp_type rsp_data
);
   import rmth_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       load;
   logic       full_flag;
   rsp_type    dp_rsp;

   rmth_ctrl u_ctrl (
      .clock, .reset, .start, .restart(req_data.restart), .sts, .busy, .load,
      .cmd, .rsp_valid, .full_flag);

   rmth_datapath #(.HEAP_DEPTH(HEAP_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
      .clock, .reset, .load, .req(req_data), .cmd, .sts, .rsp_data(dp_rsp));

   always_comb begin
      rsp_data          = dp_rsp;
      rsp_data.full_res = full_flag;
   end

   // no accept while busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   // result frees the block
   a_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy after result");
   // one-cycle strobe
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("strobe too long");

endmodule
